>>> hw/rtl/ssoc_pkg.sv
// Shared constants and types for the subsequence occurrence counter.
// No dependencies; used by ssoc_front, ssoc_back and the top level.
package ssoc_pkg;

  localparam int PATTERN_DEPTH = 16;
  localparam int COUNT_WIDTH   = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int WORD_W   = 32;
  localparam int CFG_W    = 5;
  localparam int RESULT_W = 16;
  localparam int PTR_W    = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int FILL_W   = $clog2(PATTERN_DEPTH + 1);
  localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] CFG_LEN_RESET = CFG_W'(1);

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  typedef logic signed [WORD_W-1:0] word_t;

  // Classified beat as it sits in the queue between front and back.
  typedef struct packed {
    logic  is_text;
    logic  is_last;
    word_t word;
  } item_t;

endpackage

>>> hw/rtl/ssoc_front.sv
// Front end of the subsequence occurrence counter: accepts input beats,
// classifies them and holds them in a short queue for the back end.
// Depends on ssoc_pkg.
module ssoc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_req_type,
  input  ssoc_pkg::word_t         in_word_value,
  input  logic                    in_is_last,
  output logic                    q_valid,
  input  logic                    q_ready,
  output ssoc_pkg::item_t         q_item
);

  ssoc_pkg::item_t                  mem_r [ssoc_pkg::QUEUE_DEPTH];
  logic [ssoc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ssoc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ssoc_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             push, pop;
  ssoc_pkg::item_t                  in_item;

  always_comb begin
    in_item.is_text = (in_req_type == ssoc_pkg::REQ_TEXT);
    in_item.is_last = in_is_last;
    in_item.word    = in_word_value;
  end

  assign in_ready = (cnt_r != ssoc_pkg::QCNT_W'(ssoc_pkg::QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid & in_ready;
  assign pop      = q_valid & q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ssoc_pkg::QPTR_W'(ssoc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ssoc_pkg::QPTR_W'(ssoc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

>>> hw/rtl/ssoc_back.sv
// Back end of the subsequence occurrence counter: pattern store, sliding
// text window, parallel compare, saturating count and the result register.
// Depends on ssoc_pkg.
module ssoc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ssoc_pkg::CFG_W-1:0]  pattern_length,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  ssoc_pkg::item_t             q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ssoc_pkg::RESULT_W-1:0] out_match_count,
  output logic                        out_found
);

  localparam int DEPTH  = ssoc_pkg::PATTERN_DEPTH;
  localparam int PTR_W  = ssoc_pkg::PTR_W;
  localparam int FILL_W = ssoc_pkg::FILL_W;
  localparam int CNT_W  = ssoc_pkg::COUNT_WIDTH;

  ssoc_pkg::word_t       pat_r    [DEPTH];
  ssoc_pkg::word_t       window_r [DEPTH];
  ssoc_pkg::word_t       win_shift[DEPTH];
  logic [FILL_W-1:0]     sel_idx  [DEPTH];
  logic [DEPTH-1:0]      lane_ok;

  logic [PTR_W-1:0]      load_ptr_r, load_ptr_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [FILL_W-1:0]     len_act;
  logic                  hit;
  logic                  take, take_pat, take_text, emit;

  logic                         out_valid_r;
  logic [ssoc_pkg::RESULT_W-1:0] out_count_r;
  logic                         out_found_r;

  // A text beat marked last needs the result slot; everything else goes.
  assign q_ready   = !(q_item.is_text && q_item.is_last) || !out_valid_r || out_ready;
  assign take      = q_valid & q_ready;
  assign take_pat  = take & !q_item.is_text;
  assign take_text = take & q_item.is_text;
  assign emit      = take_text & q_item.is_last;

  // Zero length acts as one, oversize clamps to the store depth.
  always_comb begin
    if (pattern_length == '0) begin
      len_act = FILL_W'(1);
    end else if (32'(pattern_length) > 32'(DEPTH)) begin
      len_act = FILL_W'(DEPTH);
    end else begin
      len_act = FILL_W'(pattern_length);
    end
  end

  // Window after this beat shifts in: entry k is the word k beats back.
  always_comb begin
    win_shift[0] = q_item.word;
    for (int k = 1; k < DEPTH; k++) begin
      win_shift[k] = window_r[k-1];
    end
  end

  // Pattern word j lines up with window entry len-1-j.
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      sel_idx[j] = len_act - FILL_W'(1) - FILL_W'(j);
      lane_ok[j] = (FILL_W'(j) >= len_act) ||
                   (pat_r[j] == win_shift[sel_idx[j][PTR_W-1:0]]);
    end
  end

  always_comb begin
    fill_nxt  = (fill_r == FILL_W'(DEPTH)) ? fill_r : fill_r + 1'b1;
    hit       = (fill_nxt >= len_act) && (&lane_ok);
    count_nxt = (hit && (count_r != '1)) ? count_r + 1'b1 : count_r;
    load_ptr_nxt = (q_item.is_last || (load_ptr_r == PTR_W'(DEPTH - 1))) ?
                   '0 : load_ptr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r  <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take_pat) begin
        load_ptr_r <= load_ptr_nxt;
      end
      if (take_text) begin
        fill_r  <= q_item.is_last ? '0 : fill_nxt;
        count_r <= q_item.is_last ? '0 : count_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload storage; stale window entries are masked by the fill count.
  always_ff @(posedge clk) begin
    if (take_pat) begin
      pat_r[load_ptr_r] <= q_item.word;
    end
    if (take_text) begin
      window_r <= win_shift;
    end
    if (emit) begin
      out_count_r <= ssoc_pkg::RESULT_W'(count_nxt);
      out_found_r <= (count_nxt != '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_count = out_count_r;
  assign out_found       = out_found_r;

endmodule

>>> hw/rtl/subsequence_occurrence_counter.sv
// Top level of the subsequence occurrence counter: pattern length register,
// front end with its queue, and back end. Depends on ssoc_pkg, ssoc_front, ssoc_back.
//
// Counts overlapping occurrences of a pattern of up to 16 signed 32-bit
// words in a stream of text words. Load the pattern as beats with
// req_type 0 (is_last on the final word rewinds the load pointer), set
// pattern_length, then stream text beats with req_type 1. The beat with
// is_last set produces one result (saturating 16-bit count and a found
// flag) and restarts the window fill and the count. One beat per clock is
// accepted sustained while results are taken; the back end shifts the
// window and compares all pattern words in the cycle it takes a beat, and
// a two-entry queue absorbs input beats while a result waits. A last beat
// passes the queue and then the result register. Write pattern_length only while idle.
module subsequence_occurrence_counter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic signed [31:0]            in_word_value,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_match_count,
  output logic                          out_found,
  input  logic                          cfg_wr_en,
  input  logic [4:0]                    cfg_wr_data
);

  logic [ssoc_pkg::CFG_W-1:0] pat_len_r;
  logic                       q_valid, q_ready;
  ssoc_pkg::item_t            q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= ssoc_pkg::CFG_LEN_RESET;
    end else if (cfg_wr_en) begin
      pat_len_r <= cfg_wr_data;
    end
  end

  ssoc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_word_value (in_word_value),
    .in_is_last    (in_is_last),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  ssoc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pattern_length  (pat_len_r),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_count (out_match_count),
    .out_found       (out_found)
  );

endmodule

>>> bench/tb_subsequence_occurrence_counter.sv
`timescale 1ns / 100ps
// Self-checking bench for subsequence_occurrence_counter: directed and random beats,
// with results checked against an in-bench predictor. Depends on ssoc_pkg and the RTL.
module tb_subsequence_occurrence_counter;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS   = 300;

  typedef struct packed {
    logic [ssoc_pkg::RESULT_W-1:0] count;
    logic                          found;
  } tally_t;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic                          in_req_type    = ssoc_pkg::REQ_PATTERN;
  ssoc_pkg::word_t               in_word_value  = '0;
  logic                          in_is_last     = 1'b0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic [ssoc_pkg::RESULT_W-1:0] out_match_count;
  logic                          out_found;
  logic                          cfg_wr_en      = 1'b0;
  logic [ssoc_pkg::CFG_W-1:0]    cfg_wr_data    = '0;

  // Predictor state
  ssoc_pkg::word_t                  pat_mem [ssoc_pkg::PATTERN_DEPTH];
  ssoc_pkg::word_t                  win_mem [ssoc_pkg::PATTERN_DEPTH];
  logic [ssoc_pkg::PTR_W-1:0]       load_ptr;
  logic [ssoc_pkg::FILL_W-1:0]      win_fill;
  logic [ssoc_pkg::COUNT_WIDTH-1:0] hit_count;
  logic [ssoc_pkg::CFG_W-1:0]       len_reg;

  tally_t pending_tallies[$];
  int     errors         = 0;
  int     beats_sent     = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     quiet_cycles   = 0;

  subsequence_occurrence_counter DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_word_value   (in_word_value),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_count (out_match_count),
    .out_found       (out_found),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int active_len();
    if (len_reg == 0) return 1;
    if (len_reg > ssoc_pkg::PATTERN_DEPTH) return ssoc_pkg::PATTERN_DEPTH;
    return int'(len_reg);
  endfunction

  task automatic predict_beat(input logic req, input ssoc_pkg::word_t w, input logic last);
    int     len;
    bit     hit;
    tally_t t;
    if (req == ssoc_pkg::REQ_PATTERN) begin
      pat_mem[load_ptr] = w;
      load_ptr = last ? '0 : load_ptr + 1'b1;
    end else begin
      for (int k = ssoc_pkg::PATTERN_DEPTH - 1; k > 0; k--) win_mem[k] = win_mem[k-1];
      win_mem[0] = w;
      if (win_fill < ssoc_pkg::PATTERN_DEPTH) win_fill++;
      len = active_len();
      hit = (win_fill >= len);
      // oldest word in the window lines up with pattern entry 0
      for (int j = 0; j < len; j++) begin
        if (win_mem[len-1-j] !== pat_mem[j]) hit = 1'b0;
      end
      if (hit && hit_count != '1) hit_count++;
      if (last) begin
        t.count = hit_count[ssoc_pkg::RESULT_W-1:0];
        t.found = (hit_count != 0);
        pending_tallies.push_back(t);
        foreach (win_mem[k]) win_mem[k] = '0;
        win_fill  = '0;
        hit_count = '0;
      end
    end
  endtask

  task automatic send_beat(input logic req, input ssoc_pkg::word_t w, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_word_value <= w;
    in_is_last    <= last;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    predict_beat(req, w, last);
  endtask

  // Drop valid, wait for every pending result, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input logic [ssoc_pkg::CFG_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_reg = v;
  endtask

  // Fills the whole store so no later compare touches an unwritten entry.
  task automatic test_reset_length();
    ssoc_pkg::word_t seed_pat [ssoc_pkg::PATTERN_DEPTH];
    foreach (seed_pat[k]) seed_pat[k] = $urandom;
    seed_pat[0] = 32'h7FFF_FFFF;
    seed_pat[1] = 32'h8000_0000;
    seed_pat[2] = 32'h0000_0000;
    seed_pat[3] = 32'hFFFF_FFFF;
    for (int k = 0; k < ssoc_pkg::PATTERN_DEPTH; k++)
      send_beat(ssoc_pkg::REQ_PATTERN, seed_pat[k], k == ssoc_pkg::PATTERN_DEPTH - 1);
    // length still at its reset value of one
    send_beat(ssoc_pkg::REQ_TEXT, seed_pat[0], 1'b0);
    send_beat(ssoc_pkg::REQ_TEXT, seed_pat[0], 1'b0);
    send_beat(ssoc_pkg::REQ_TEXT, seed_pat[1], 1'b1);
    drain();
  endtask

  task automatic test_short_text();
    write_len(5'd3);
    send_beat(ssoc_pkg::REQ_TEXT, pat_mem[0], 1'b0);
    send_beat(ssoc_pkg::REQ_TEXT, pat_mem[1], 1'b1);
    drain();
  endtask

  task automatic test_overlap();
    ssoc_pkg::word_t a;
    a = 32'h5A5A_A5A5;
    write_len(5'd2);
    send_beat(ssoc_pkg::REQ_PATTERN, a, 1'b0);
    send_beat(ssoc_pkg::REQ_PATTERN, a, 1'b1);
    repeat (2) send_beat(ssoc_pkg::REQ_TEXT, a, 1'b0);
    send_beat(ssoc_pkg::REQ_TEXT, a, 1'b1);
    drain();
  endtask

  task automatic test_length_clamp();
    write_len(5'd0);
    send_beat(ssoc_pkg::REQ_TEXT, pat_mem[0], 1'b1);
    drain();
    write_len(5'd31);
    send_beat(ssoc_pkg::REQ_TEXT, pat_mem[0], 1'b0);
    send_beat(ssoc_pkg::REQ_TEXT, pat_mem[1], 1'b0);
    send_beat(ssoc_pkg::REQ_TEXT, pat_mem[2], 1'b1);
    drain();
  endtask

  // Window and count survive a length change and a pattern load mid-text.
  task automatic test_midtext_update();
    ssoc_pkg::word_t b;
    b = 32'hC0DE_0001;
    write_len(5'd1);
    send_beat(ssoc_pkg::REQ_TEXT, pat_mem[0], 1'b0);
    drain();
    write_len(5'd2);
    send_beat(ssoc_pkg::REQ_PATTERN, b, 1'b1);
    send_beat(ssoc_pkg::REQ_TEXT, b, 1'b0);
    send_beat(ssoc_pkg::REQ_TEXT, pat_mem[1], 1'b1);
    drain();
  endtask

  // Well-formed run: set a length, load a pattern, stream text with planted copies.
  task automatic random_text_run();
    ssoc_pkg::word_t            alpha [3];
    logic [ssoc_pkg::CFG_W-1:0] cfg;
    int                         len;
    int                         n_load;
    int                         n_txt;
    int                         k;
    drain();
    case ($urandom_range(9))
      0:       cfg = '0;
      1:       cfg = ssoc_pkg::CFG_W'($urandom_range(ssoc_pkg::PATTERN_DEPTH + 1, 31));
      2:       cfg = ssoc_pkg::CFG_W'(ssoc_pkg::PATTERN_DEPTH);
      3:       cfg = ssoc_pkg::CFG_W'(1);
      default: cfg = ssoc_pkg::CFG_W'($urandom_range(1, ssoc_pkg::PATTERN_DEPTH));
    endcase
    write_len(cfg);
    len = active_len();
    foreach (alpha[i]) alpha[i] = $urandom;
    // now and then overrun the store so the load pointer wraps
    n_load = ($urandom_range(19) == 0) ?
             ssoc_pkg::PATTERN_DEPTH + $urandom_range(1, 8) : len;
    for (int i = 0; i < n_load; i++)
      send_beat(ssoc_pkg::REQ_PATTERN, alpha[$urandom_range(2)], i == n_load - 1);
    n_txt = $urandom_range(1, 3 * len + 6);
    k = 0;
    while (k < n_txt) begin
      if ($urandom_range(3) == 0 && k + len <= n_txt) begin
        for (int j = 0; j < len; j++)
          send_beat(ssoc_pkg::REQ_TEXT, pat_mem[j], k + j == n_txt - 1);
        k += len;
      end else begin
        send_beat(ssoc_pkg::REQ_TEXT, alpha[$urandom_range(2)], k == n_txt - 1);
        k++;
      end
      if (k < n_txt && $urandom_range(49) == 0)
        send_beat(ssoc_pkg::REQ_PATTERN, alpha[$urandom_range(2)], 1'b1);
    end
  endtask

  task automatic random_noise();
    repeat ($urandom_range(1, 6))
      send_beat($urandom_range(1) ? ssoc_pkg::REQ_TEXT : ssoc_pkg::REQ_PATTERN, $urandom,
                $urandom_range(3) == 0);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    int start;
    drain();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = beats_sent;
    while (beats_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(9) < 8) random_text_run();
      else random_noise();
    end
    drain();
  endtask

  always @(posedge clk) begin : result_check
    tally_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tallies.size() == 0) begin
        $error("unexpected result: match_count %0d found %0d", out_match_count, out_found);
        errors++;
      end else begin
        want = pending_tallies.pop_front();
        if (out_match_count !== want.count) begin
          $error("match_count: expected %0d, got %0d", want.count, out_match_count);
          errors++;
        end
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          errors++;
        end
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    foreach (win_mem[k]) win_mem[k] = '0;
    load_ptr  = '0;
    win_fill  = '0;
    hit_count = '0;
    len_reg   = ssoc_pkg::CFG_LEN_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_length();
    test_short_text();
    test_overlap();
    test_length_clamp();
    test_midtext_update();
    test_random_phase(0, 0);
    test_random_phase(62, 0);
    test_random_phase(0, 62);
    test_random_phase(20, 20);

    drain();
    if (errors == 0 && pending_tallies.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ssoc_pkg.sv
hw/rtl/ssoc_front.sv
hw/rtl/ssoc_back.sv
hw/rtl/subsequence_occurrence_counter.sv
bench/tb_subsequence_occurrence_counter.sv
